>>> src/rtnz_pkg.sv
// Shared types and constants for the rotate-to-new-z-axis datapath.
package rtnz_pkg;

   localparam int FRAC_BITS_DEF = 30;
   localparam int NUM_W         = 98;
   localparam int QUO_W         = 33;
   localparam int ROOT_STEPS    = 32;
   localparam int RAD_W         = 64;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] ux;
      logic signed [31:0] uy;
      logic signed [31:0] uz;
   } vec_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [NUM_W-1:0] mag;
      logic [RAD_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } comp_type;

   typedef struct packed {
      logic [RAD_W-1:0] den;
      comp_type [2:0]   comp;
   } div_type;

endpackage

>>> src/rtnz_sqrt_cell.sv
// One digit cell of the integer square-root chain.
module rtnz_sqrt_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [rtnz_pkg::RAD_W-1:0]          in_rad,
   input  logic [rtnz_pkg::RAD_W-1:0]          in_root,
   input  rtnz_pkg::vec_type                   in_vec,
   output logic                                out_valid,
   output logic [rtnz_pkg::RAD_W-1:0]          out_rad,
   output logic [rtnz_pkg::RAD_W-1:0]          out_root,
   output rtnz_pkg::vec_type                   out_vec
);

   localparam logic [rtnz_pkg::RAD_W-1:0] ONE_BIT = rtnz_pkg::RAD_W'(1) << (2 * BIT_POS);

   logic                          valid_ff;
   logic [rtnz_pkg::RAD_W-1:0]    trial;
   logic [rtnz_pkg::RAD_W-1:0]    rad_in, rad_ff, root_in, root_ff;
   rtnz_pkg::vec_type             vec_ff;

   // try this result bit and keep it where the radicand allows
   assign trial = in_root + ONE_BIT;

   always_comb begin
      if (in_rad >= trial) begin
         rad_in  = in_rad - trial;
         root_in = (in_root >> 1) + ONE_BIT;
      end else begin
         rad_in  = in_rad;
         root_in = in_root >> 1;
      end
   end

   // advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         vec_ff  <= in_vec;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_root  = root_ff;
   assign out_vec   = vec_ff;

endmodule

>>> src/rtnz_div_cell.sv
// One quotient-bit cell of the restoring divider chain, three components wide.
module rtnz_div_cell #(
   parameter int BIT_POS = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rtnz_pkg::div_type in_div,
   output logic              out_valid,
   output rtnz_pkg::div_type out_div
);

   logic                          valid_ff;
   rtnz_pkg::div_type             div_in, div_ff;
   logic [rtnz_pkg::RAD_W-1:0]    part [3];

   // shift in the next numerator bit and subtract where it fits
   always_comb begin
      div_in = in_div;
      for (int c = 0; c < 3; c++) begin
         part[c] = {in_div.comp[c].rem[rtnz_pkg::RAD_W-2:0], in_div.comp[c].mag[BIT_POS]};
         if (part[c] >= in_div.den) begin
            div_in.comp[c].rem          = part[c] - in_div.den;
            div_in.comp[c].quo[BIT_POS] = 1'b1;
         end else begin
            div_in.comp[c].rem = part[c];
         end
      end
   end

   // advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;

endmodule

>>> src/rtnz_prod.sv
// Product and numerator stages between the square root and the divider.
module rtnz_prod #(
   parameter int FRAC_BITS = rtnz_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rtnz_pkg::vec_type in_vec,
   input  logic [31:0]       in_root,
   output logic              out_valid,
   output rtnz_pkg::div_type out_div
);

   localparam int NW = rtnz_pkg::NUM_W;
   localparam int QW = rtnz_pkg::QUO_W;
   localparam int RW = rtnz_pkg::RAD_W;

   logic [4:0]             valid_ff;
   logic signed [32:0]     root_s;

   // stage A: axis products
   logic signed [64:0]     a_m_in [6];
   logic signed [64:0]     a_m_ff [6];
   logic signed [63:0]     a_yp_in, a_yp_ff, a_xp_in, a_xp_ff;
   rtnz_pkg::vec_type      a_vec_ff;
   logic [31:0]            a_root_ff;

   // stage B: partial products against the vector
   logic signed [31:0]     b_mult [6];
   logic signed [65:0]     b_lo_in [6];
   logic signed [65:0]     b_lo_ff [6];
   logic signed [65:0]     b_hi_in [6];
   logic signed [65:0]     b_hi_ff [6];
   logic signed [63:0]     b_yp_ff, b_xp_ff;
   rtnz_pkg::vec_type      b_vec_ff;
   logic [31:0]            b_root_ff;

   // stage C: full terms
   logic signed [NW-1:0]   c_hi [6];
   logic signed [NW-1:0]   c_lo [6];
   logic signed [NW-1:0]   c_t_in [6];
   logic signed [NW-1:0]   c_t_ff [6];
   logic signed [NW-1:0]   c_yp_ext, c_xp_ext, c_px_ext;
   logic signed [NW-1:0]   c_yp_in, c_yp_ff, c_xp_in, c_xp_ff, c_px_in, c_px_ff;
   rtnz_pkg::vec_type      c_vec_ff;
   logic [31:0]            c_root_ff;

   // stage D: numerators and divisor
   logic                   d_zero;
   logic signed [NW-1:0]   d_px, d_py, d_pz;
   logic signed [NW-1:0]   d_n_in [3];
   logic signed [NW-1:0]   d_n_ff [3];
   logic [RW-1:0]          d_den_in, d_den_ff;

   // stage E: sign, magnitude and range check
   logic [NW-1:0]          e_lim;
   rtnz_pkg::div_type      e_div_in, e_div_ff;

   assign root_s = $signed({1'b0, in_root});

   always_comb begin
      a_m_in[0] = $signed(in_vec.ux) * $signed(in_vec.uz);
      a_m_in[1] = $signed(in_vec.uy) * $signed(in_vec.uz);
      a_m_in[2] = $signed(in_vec.uz) * $signed(in_vec.uz);
      a_m_in[3] = $signed(in_vec.ux) * root_s;
      a_m_in[4] = $signed(in_vec.uy) * root_s;
      a_m_in[5] = $signed(in_vec.uz) * root_s;
      a_yp_in   = $signed(in_vec.uy) * $signed(in_vec.py);
      a_xp_in   = $signed(in_vec.ux) * $signed(in_vec.py);
   end

   // split each axis product in halves against px or pz
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         b_mult[k]  = (k < 3) ? $signed(a_vec_ff.px) : $signed(a_vec_ff.pz);
         b_lo_in[k] = $signed({1'b0, a_m_ff[k][31:0]}) * b_mult[k];
         b_hi_in[k] = $signed(a_m_ff[k][64:32]) * b_mult[k];
      end
   end

   // recombine halves and align the lone terms
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         c_hi[k]   = b_hi_ff[k];
         c_lo[k]   = b_lo_ff[k];
         c_t_in[k] = (c_hi[k] <<< 32) + c_lo[k];
      end
      c_yp_ext = b_yp_ff;
      c_xp_ext = b_xp_ff;
      c_px_ext = $signed(b_vec_ff.px);
      c_yp_in  = c_yp_ext <<< FRAC_BITS;
      c_xp_in  = c_xp_ext <<< FRAC_BITS;
      c_px_in  = c_px_ext <<< (2 * FRAC_BITS);
   end

   // form numerators; an axis on the z line turns into a unit divide
   always_comb begin
      d_zero = (c_root_ff == 32'd0);
      d_px   = $signed(c_vec_ff.px);
      d_py   = $signed(c_vec_ff.py);
      d_pz   = $signed(c_vec_ff.pz);
      if (d_zero) begin
         d_n_in[0] = (c_vec_ff.uz[31] ? -d_px : d_px) <<< FRAC_BITS;
         d_n_in[1] = d_py <<< FRAC_BITS;
         d_n_in[2] = (c_vec_ff.uz[31] ? -d_pz : d_pz) <<< FRAC_BITS;
         d_den_in  = RW'(1) << FRAC_BITS;
      end else begin
         d_n_in[0] = c_t_ff[0] - c_yp_ff + c_t_ff[3];
         d_n_in[1] = c_t_ff[1] + c_xp_ff + c_t_ff[4];
         d_n_in[2] = c_t_ff[2] - c_px_ff + c_t_ff[5];
         d_den_in  = RW'(c_root_ff) << FRAC_BITS;
      end
   end

   // take magnitudes and flag quotients that cannot fit
   always_comb begin
      e_lim        = NW'(d_den_ff) << QW;
      e_div_in.den = d_den_ff;
      for (int c = 0; c < 3; c++) begin
         e_div_in.comp[c].neg = d_n_ff[c][NW-1];
         e_div_in.comp[c].mag = d_n_ff[c][NW-1] ? NW'(-d_n_ff[c]) : NW'(d_n_ff[c]);
         e_div_in.comp[c].ovf = (e_div_in.comp[c].mag >= e_lim);
         e_div_in.comp[c].rem = RW'(e_div_in.comp[c].mag >> QW);
         e_div_in.comp[c].quo = '0;
      end
   end

   // advance the valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 6; k++) begin
            a_m_ff[k]  <= a_m_in[k];
            b_lo_ff[k] <= b_lo_in[k];
            b_hi_ff[k] <= b_hi_in[k];
            c_t_ff[k]  <= c_t_in[k];
         end
         for (int c = 0; c < 3; c++) begin
            d_n_ff[c] <= d_n_in[c];
         end
         a_yp_ff   <= a_yp_in;
         a_xp_ff   <= a_xp_in;
         a_vec_ff  <= in_vec;
         a_root_ff <= in_root;
         b_yp_ff   <= a_yp_ff;
         b_xp_ff   <= a_xp_ff;
         b_vec_ff  <= a_vec_ff;
         b_root_ff <= a_root_ff;
         c_yp_ff   <= c_yp_in;
         c_xp_ff   <= c_xp_in;
         c_px_ff   <= c_px_in;
         c_vec_ff  <= b_vec_ff;
         c_root_ff <= b_root_ff;
         d_den_ff  <= d_den_in;
         e_div_ff  <= e_div_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_div   = e_div_ff;

endmodule

>>> src/rotate_to_new_z_axis.sv
// Top level: rotate a vector into the frame whose z axis is a given direction.
// Stages from an accepted request to rsp_valid: 2 input, 32 root, 5 product,
// 33 divide and 1 output register stage.
// Throughput: one transfer per cycle while the pipeline is not held; every stage is a cell of a single pipeline.
// The pipeline holds only while its last cell has a result and the output is stalled.
// Reset (synchronous) clears all valid flags; no clearing pass is needed.
module rotate_to_new_z_axis #(
   parameter int FRAC_BITS = rtnz_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_clipped
);

   localparam int STEPS = rtnz_pkg::ROOT_STEPS;
   localparam int QW    = rtnz_pkg::QUO_W;
   localparam int RW    = rtnz_pkg::RAD_W;

   logic                  adv;

   // input stage and radicand
   logic                  s0_valid_ff, s1_valid_ff;
   rtnz_pkg::vec_type     s0_vec_in, s0_vec_ff, s1_vec_ff;
   logic [62:0]           s0_sqx_in, s0_sqx_ff, s0_sqy_in, s0_sqy_ff;
   logic [RW-1:0]         s1_sum_in, s1_sum_ff;

   // root chain
   logic                  sq_valid [STEPS+1];
   logic [RW-1:0]         sq_rad   [STEPS+1];
   logic [RW-1:0]         sq_root  [STEPS+1];
   rtnz_pkg::vec_type     sq_vec   [STEPS+1];

   // divider chain
   logic                  dv_valid [QW+1];
   rtnz_pkg::div_type     dv_data  [QW+1];

   // output register
   logic                  rsp_valid_ff, rsp_clipped_in, rsp_clipped_ff, rsp_load;
   logic [32:0]           lim   [3];
   logic                  clip  [3];
   logic signed [31:0]    res_in [3];
   logic signed [31:0]    res_ff [3];

   // hold the pipeline only when the last cell cannot drain
   assign adv       = !(dv_valid[QW] && rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;

   // capture request and square the x and y axis components
   always_comb begin
      s0_vec_in = '{px: req_vec_x, py: req_vec_y, pz: req_vec_z,
                    ux: req_axis_x, uy: req_axis_y, uz: req_axis_z};
      s0_sqx_in = 63'($signed(req_axis_x) * $signed(req_axis_x));
      s0_sqy_in = 63'($signed(req_axis_y) * $signed(req_axis_y));
      s1_sum_in = RW'(s0_sqx_ff) + RW'(s0_sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_vec_ff <= s0_vec_in;
         s0_sqx_ff <= s0_sqx_in;
         s0_sqy_ff <= s0_sqy_in;
         s1_vec_ff <= s0_vec_ff;
         s1_sum_ff <= s1_sum_in;
      end
   end

   assign sq_valid[0] = s1_valid_ff;
   assign sq_rad[0]   = s1_sum_ff;
   assign sq_root[0]  = '0;
   assign sq_vec[0]   = s1_vec_ff;

   // root chain, most significant result bit first
   for (genvar k = 0; k < STEPS; k++) begin : g_root
      rtnz_sqrt_cell #(.BIT_POS(STEPS - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_valid[k]),
         .in_rad    (sq_rad[k]),
         .in_root   (sq_root[k]),
         .in_vec    (sq_vec[k]),
         .out_valid (sq_valid[k+1]),
         .out_rad   (sq_rad[k+1]),
         .out_root  (sq_root[k+1]),
         .out_vec   (sq_vec[k+1])
      );
   end

   rtnz_prod #(.FRAC_BITS(FRAC_BITS)) u_prod (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid[STEPS]),
      .in_vec    (sq_vec[STEPS]),
      .in_root   (sq_root[STEPS][31:0]),
      .out_valid (dv_valid[0]),
      .out_div   (dv_data[0])
   );

   // divider chain, most significant quotient bit first
   for (genvar k = 0; k < QW; k++) begin : g_div
      rtnz_div_cell #(.BIT_POS(QW - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_valid[k]),
         .in_div    (dv_data[k]),
         .out_valid (dv_valid[k+1]),
         .out_div   (dv_data[k+1])
      );
   end

   // saturate quotients and apply signs
   always_comb begin
      rsp_clipped_in = 1'b0;
      for (int c = 0; c < 3; c++) begin
         lim[c]  = dv_data[QW].comp[c].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
         clip[c] = dv_data[QW].comp[c].ovf || (dv_data[QW].comp[c].quo > lim[c]);
         if (clip[c]) begin
            res_in[c] = dv_data[QW].comp[c].neg ? rtnz_pkg::SAT_MIN : rtnz_pkg::SAT_MAX;
         end else if (dv_data[QW].comp[c].neg) begin
            res_in[c] = $signed(32'(33'd0 - dv_data[QW].comp[c].quo));
         end else begin
            res_in[c] = $signed(dv_data[QW].comp[c].quo[31:0]);
         end
         rsp_clipped_in = rsp_clipped_in | clip[c];
      end
   end

   // output register: load when empty or when the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= dv_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load && dv_valid[QW]) begin
         for (int c = 0; c < 3; c++) begin
            res_ff[c] <= res_in[c];
         end
         rsp_clipped_ff <= rsp_clipped_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = res_ff[0];
   assign rsp_out_y   = res_ff[1];
   assign rsp_out_z   = res_ff[2];
   assign rsp_clipped = rsp_clipped_ff;

   // a clipped result always carries at least one saturated component
   a_clip_sat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clipped_ff |->
         res_ff[0] == rtnz_pkg::SAT_MAX || res_ff[0] == rtnz_pkg::SAT_MIN ||
         res_ff[1] == rtnz_pkg::SAT_MAX || res_ff[1] == rtnz_pkg::SAT_MIN ||
         res_ff[2] == rtnz_pkg::SAT_MAX || res_ff[2] == rtnz_pkg::SAT_MIN)
      else $error("clipped result without a saturated component");

   // in-range divisions end with a remainder below the divisor
   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      dv_valid[QW] |->
         (dv_data[QW].comp[0].ovf || dv_data[QW].comp[0].rem < dv_data[QW].den) &&
         (dv_data[QW].comp[1].ovf || dv_data[QW].comp[1].rem < dv_data[QW].den) &&
         (dv_data[QW].comp[2].ovf || dv_data[QW].comp[2].rem < dv_data[QW].den))
      else $error("divider remainder not below divisor");

   // a blocked last cell keeps its result until the output drains
   a_hold_last : assert property (@(posedge clock) disable iff (reset)
      dv_valid[QW] && rsp_valid_ff && rsp_stall |=> dv_valid[QW] && $stable(dv_data[QW]))
      else $error("last divider cell changed while blocked");

   // the root chain leaves a remainder no larger than twice the root
   a_root_rem : assert property (@(posedge clock) disable iff (reset)
      sq_valid[STEPS] |-> sq_rad[STEPS] <= (sq_root[STEPS] << 1))
      else $error("root remainder too large");

endmodule

>>> bench/tb.sv
// Self-checking bench for the rotate-to-new-z-axis pipeline.
`timescale 1ns / 100ps

// Expected rotated vectors, in transfer order, and the comparison against them.
class rotation_board;
   typedef struct {
      logic signed [31:0] x, y, z;
      logic               clip;
   } rot_result;

   rot_result pending[$];
   int        n_errors;
   int        n_checked;
   int        n_clipped;
   int        n_vertical;

   // Saturate a wide signed value to 32 bits and note any clipping.
   function automatic logic signed [31:0] clamp(input logic signed [159:0] v,
                                                inout logic c);
      if (v > 160'sh7FFF_FFFF) begin
         c = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -160'sh8000_0000) begin
         c = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // Integer square root, floor.
   function automatic logic [63:0] floor_root(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Quotient truncated toward zero.
   function automatic logic signed [159:0] div_trunc(input logic signed [159:0] n,
                                                     input logic signed [159:0] d);
      logic signed [159:0] m;
      logic signed [159:0] q;
      m = (n < 0) ? -n : n;
      q = m / d;
      return (n < 0) ? -q : q;
   endfunction

   // Work out the rotated vector for one accepted transfer.
   function void note_transfer(input logic signed [31:0] px, py, pz, ux, uy, uz);
      logic signed [159:0] sx, sy, sz, wx, wy, wz, wss, d, nx, ny, nz;
      logic [63:0]         sum;
      rot_result           r;
      sx = px; sy = py; sz = pz; wx = ux; wy = uy; wz = uz;
      r.clip = 1'b0;
      sum = 64'(wx * wx + wy * wy);
      if (sum != 0) begin
         wss = {96'd0, floor_root(sum)};
         d = wss <<< 30;
         nx = wx * wz * sx - ((wy * sy) <<< 30) + wx * wss * sz;
         ny = wy * wz * sx + ((wx * sy) <<< 30) + wy * wss * sz;
         nz = wz * wz * sx - (sx <<< 60) + wz * wss * sz;
         r.x = clamp(div_trunc(nx, d), r.clip);
         r.y = clamp(div_trunc(ny, d), r.clip);
         r.z = clamp(div_trunc(nz, d), r.clip);
      end else if (uz < 0) begin
         n_vertical++;
         r.x = clamp(-sx, r.clip);
         r.y = py;
         r.z = clamp(-sz, r.clip);
      end else begin
         n_vertical++;
         r.x = px; r.y = py; r.z = pz;
      end
      if (r.clip) n_clipped++;
      pending.push_back(r);
   endfunction

   // Compare one returned vector with the oldest expectation.
   function void check_result(input logic signed [31:0] x, y, z, input logic c);
      rot_result e;
      if (pending.size() == 0) begin
         n_errors++;
         if (n_errors <= 10) $display("unexpected result %h %h %h %b", x, y, z, c);
         return;
      end
      e = pending.pop_front();
      n_checked++;
      if (x !== e.x || y !== e.y || z !== e.z || c !== e.clip) begin
         n_errors++;
         if (n_errors <= 10)
            $display("mismatch: expected %h %h %h %b, got %h %h %h %b",
                     e.x, e.y, e.z, e.clip, x, y, z, c);
      end
   endfunction
endclass

module tb;

   localparam logic signed [31:0] ONE = 32'sh4000_0000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_vec_x, req_vec_y, req_vec_z;
   logic signed [31:0] req_axis_x, req_axis_y, req_axis_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic               rsp_clipped;

   rotation_board board;
   int            send_idle_pct;
   int            recv_stall_pct;
   bit            stim_done;

   rotate_to_new_z_axis i_dut (.*);

   // Free-running clock.
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Check each result transfer at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_out_x, rsp_out_y, rsp_out_z, rsp_clipped);
   end

   // Stall the result channel at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Random word, biased towards the extremes now and then.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(ONE);
         3: return 32'(-ONE);
         default: return $urandom;
      endcase
   endfunction

   // Present one transfer, hold it through any stall, idle at random first.
   task automatic send_vector(input logic [31:0] px, py, pz, ux, uy, uz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_vec_x  <= px;
      req_vec_y  <= py;
      req_vec_z  <= pz;
      req_axis_x <= ux;
      req_axis_y <= uy;
      req_axis_z <= uz;
      do @(posedge clock); while (req_stall);
      board.note_transfer(px, py, pz, ux, uy, uz);
      @(negedge clock);
   endtask

   // Random item: mostly axes with components within +/-ONE, sometimes vertical or raw noise.
   task automatic send_random();
      logic signed [31:0] ux, uy, uz;
      int                 k;
      k = $urandom_range(9);
      if (k < 6) begin
         ux = $signed($urandom_range(2 * ONE)) - ONE;
         uy = $signed($urandom_range(2 * ONE)) - ONE;
         uz = $signed($urandom_range(2 * ONE)) - ONE;
         if (k == 0) uy = $signed($urandom_range(15)) - 8;
      end else if (k < 8) begin
         ux = 0;
         uy = 0;
         uz = rand_word();
      end else begin
         ux = rand_word();
         uy = rand_word();
         uz = rand_word();
      end
      send_vector(rand_word(), rand_word(), rand_word(), ux, uy, uz);
   endtask

   // Wait until every expected result has come back.
   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      board          = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      stim_done      = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      rsp_stall      = 1'b0;
      req_vec_x      = 0;
      req_vec_y      = 0;
      req_vec_z      = 0;
      req_axis_x     = 0;
      req_axis_y     = 0;
      req_axis_z     = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed: identity, flipped and tilted axes, extremes, odd sizes.
      send_vector(ONE, 32'h1234_5678, -ONE, 0, 0, ONE);
      send_vector(ONE, 32'h1234_5678, -ONE, 0, 0, -ONE);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, -1);
      send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      send_vector(32'h8000_0000, 5, 32'h8000_0000, 0, 0, 32'h8000_0000);
      send_vector(ONE, ONE, ONE, ONE, 0, 0);
      send_vector(ONE, ONE, ONE, 0, ONE, 0);
      send_vector(ONE, ONE, ONE, 0, -ONE, 0);
      send_vector(ONE, -ONE, ONE, 32'h2D41_3CCD, 32'h2D41_3CCD, 0);
      send_vector(ONE, 2, 3, 1, 0, ONE);
      send_vector(ONE, 2, 3, 0, -1, -ONE);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1, 1, 32'h8000_0000);
      send_vector(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h1000_0000, -32'h1000_0000, ONE);
      send_vector(ONE, ONE, ONE, 32'h8000_0000, 0, 32'h7FFF_FFFF);

      // Pause until the pipeline is empty before the random phases.
      req_valid <= 1'b0;
      drain();

      // Random phases with different idle and stall patterns.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 30 : 65) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 30 : 65) : 0;
         repeat (400) send_random();
      end
      req_valid      <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      stim_done      = 1'b1;
   end

   // Finish once stimulus is in and every result has come back.
   initial begin
      wait (stim_done);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("covered %0d rotations (%0d vertical axes, %0d with clipping)",
               board.n_checked, board.n_vertical, board.n_clipped);
      if (board.n_errors == 0 && board.pending.size() == 0)
         $display("rotate_to_new_z_axis test passed");
      else
         $display("rotate_to_new_z_axis test failed");
      $finish;
   end

   // Guard against a hung pipeline.
   initial begin
      #2_000_000;
      $display("rotate_to_new_z_axis test failed");
      $finish;
   end
endmodule
